>>> rtl/imtf_pkg.sv
// Shared types, constants and register indexes for the MFM track formatter.
// No dependencies; used by every module under rtl/.
`default_nettype none

package imtf_pkg;

    // Default for the size code ceiling parameter
    localparam int MAX_SIZE_CODE_DEF = 6;

    // Configuration register indexes
    localparam logic [2:0] CFG_CYLINDER   = 3'd0;
    localparam logic [2:0] CFG_HEAD       = 3'd1;
    localparam logic [2:0] CFG_SIZE_SHIFT = 3'd2;
    localparam logic [2:0] CFG_SECT_COUNT = 3'd3;
    localparam logic [2:0] CFG_FIRST_SECT = 3'd4;
    localparam logic [2:0] CFG_GAP3_LEN   = 3'd5;
    localparam logic [2:0] CFG_TRACK_LEN  = 3'd6;
    localparam logic [2:0] CFG_MODE       = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Stream bytes
    localparam logic [7:0] BYTE_GAP  = 8'h4E;
    localparam logic [7:0] BYTE_SYNC = 8'h00;
    localparam logic [7:0] BYTE_A1   = 8'hA1;
    localparam logic [7:0] MARK_IAM  = 8'hFC;
    localparam logic [7:0] MARK_IDAM = 8'hFE;
    localparam logic [7:0] MARK_DDAM = 8'hF8;
    localparam logic [7:0] MARK_DAM  = 8'hFB;

    // CRC-16-CCITT
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_PRESET = 16'hCDB4;

    // Section lengths in bytes
    localparam logic [14:0] LEN_GAP4A   = 15'd80;
    localparam logic [14:0] LEN_PRE     = 15'd16;
    localparam logic [14:0] LEN_GAP1    = 15'd50;
    localparam logic [14:0] LEN_IDFLD   = 15'd6;
    localparam logic [14:0] LEN_GAP2    = 15'd22;
    localparam logic [14:0] LEN_DCRC    = 15'd2;
    localparam logic [14:0] LEN_GAP3_DD = 15'd54;
    localparam logic [14:0] LEN_GAP3_HD = 15'd108;
    localparam logic [14:0] LEN_SECT128 = 15'd128;

    // Preamble positions
    localparam logic [13:0] PRE_SYNC_END = 14'd12;
    localparam logic [13:0] PRE_A1_END   = 14'd15;
    localparam logic [13:0] PRE_LAST_A1  = 14'd14;

    // ID field positions
    localparam logic [13:0] IDF_CYL    = 14'd0;
    localparam logic [13:0] IDF_HEAD   = 14'd1;
    localparam logic [13:0] IDF_SECT   = 14'd2;
    localparam logic [13:0] IDF_SIZE   = 14'd3;
    localparam logic [13:0] IDF_CRC_HI = 14'd4;

    typedef enum logic [3:0] {
        PH_GAP4A = 4'd0,
        PH_IAM   = 4'd1,
        PH_GAP1  = 4'd2,
        PH_IDPRE = 4'd3,
        PH_IDFLD = 4'd4,
        PH_GAP2  = 4'd5,
        PH_DPRE  = 4'd6,
        PH_DATA  = 4'd7,
        PH_DCRC  = 4'd8,
        PH_GAP3  = 4'd9,
        PH_FILL  = 4'd10,
        PH_DONE  = 4'd11
    } t_phase;

    typedef struct packed {
        logic [7:0]  cylinder_number;
        logic [7:0]  head_number;
        logic [2:0]  size_shift;
        logic [5:0]  sector_count;
        logic [7:0]  first_id;
        logic [7:0]  gap3_length;
        logic [15:0] track_len;
        logic [1:0]  mode_flags;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       data_taken;
        logic [5:0] sector_position;
        logic       track_done;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/ibm_mfm_track_formatter_top.sv
// The result of a request is loaded into the output register when the request is accepted.
// Throughput: one request per cycle; a new request is taken while the output register
// drains, so the rate is set only by the downstream ready.
// Reset (synchronous, active low) clears the sequencer and the output valid flag and
// loads the configuration defaults; no clearing pass is needed.
// Top level of the MFM track formatter; depends on imtf_pkg, imtf_cfg, imtf_seq.
`default_nettype none

module ibm_mfm_track_formatter_top #(
    parameter int MAX_SIZE_CODE = imtf_pkg::MAX_SIZE_CODE_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [imtf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [imtf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Request channel
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_kind,
    input  wire logic [7:0]                        i_data_byte,
    input  wire logic                              i_table_id_valid,
    input  wire logic [7:0]                        i_table_id,
    // Result channel
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [7:0]                             o_out_byte,
    output logic                                   o_out_valid,
    output logic                                   o_data_taken,
    output logic [5:0]                             o_sector_position,
    output logic                                   o_track_done
);

    imtf_pkg::t_cfg    w_cfg;
    imtf_pkg::t_result w_result;
    imtf_pkg::t_result r_result;
    logic              r_valid;
    logic              w_accept;

    imtf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    imtf_seq #(
        .MAX_SIZE_CODE (MAX_SIZE_CODE)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_kind           (i_kind),
        .i_data_byte      (i_data_byte),
        .i_table_id_valid (i_table_id_valid),
        .i_table_id       (i_table_id),
        .i_cfg            (w_cfg),
        .o_result         (w_result)
    );

    // Request taken whenever the output register is empty or being drained
    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign o_valid           = r_valid;
    assign o_out_byte        = r_result.out_byte;
    assign o_out_valid       = r_result.out_valid;
    assign o_data_taken      = r_result.data_taken;
    assign o_sector_position = r_result.sector_position;
    assign o_track_done      = r_result.track_done;

    // A done result never carries a track byte
    a_done_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_track_done) |-> (!o_out_valid && !o_data_taken && o_out_byte == 8'd0))
        else $error("done result carries track data");

    // Sector data is only consumed on a valid track byte
    a_taken_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data_taken) |-> o_out_valid)
        else $error("data taken without a track byte");

    // Every accepted request shows up in the output register next cycle
    a_accept_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_valid)
        else $error("accepted transaction lost");

endmodule

`default_nettype wire

>>> rtl/imtf_cfg.sv
// Configuration register bank for the MFM track formatter.
// Depends on imtf_pkg (register indexes, t_cfg).
`default_nettype none

module imtf_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [imtf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [imtf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output imtf_pkg::t_cfg                         o_cfg
);

    imtf_pkg::t_cfg r_cfg;

    // Register writes, reset to the power-on track layout
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cylinder_number <= 8'd0;
            r_cfg.head_number     <= 8'd0;
            r_cfg.size_shift      <= 3'd2;
            r_cfg.sector_count    <= 6'd9;
            r_cfg.first_id        <= 8'd1;
            r_cfg.gap3_length     <= 8'd0;
            r_cfg.track_len       <= 16'd12500;
            r_cfg.mode_flags      <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                imtf_pkg::CFG_CYLINDER:   r_cfg.cylinder_number <= i_cfg_data[7:0];
                imtf_pkg::CFG_HEAD:       r_cfg.head_number     <= i_cfg_data[7:0];
                imtf_pkg::CFG_SIZE_SHIFT: r_cfg.size_shift      <= i_cfg_data[2:0];
                imtf_pkg::CFG_SECT_COUNT: r_cfg.sector_count    <= i_cfg_data[5:0];
                imtf_pkg::CFG_FIRST_SECT: r_cfg.first_id        <= i_cfg_data[7:0];
                imtf_pkg::CFG_GAP3_LEN:   r_cfg.gap3_length     <= i_cfg_data[7:0];
                imtf_pkg::CFG_TRACK_LEN:  r_cfg.track_len       <= i_cfg_data[15:0];
                imtf_pkg::CFG_MODE:       r_cfg.mode_flags      <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/imtf_crc.sv
// Byte-wide CRC-16-CCITT update, MSB first.
// Depends on imtf_pkg (polynomial).
`default_nettype none

module imtf_crc (
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_crc
);

    // Eight shift steps folded into one combinational update
    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {i_byte, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (v_crc[15]) begin
                v_crc = {v_crc[14:0], 1'b0} ^ imtf_pkg::CRC_POLY;
            end else begin
                v_crc = {v_crc[14:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

`default_nettype wire

>>> rtl/imtf_seq.sv
// Track sequencer: section state, byte selection, CRC register, byte counter.
// Depends on imtf_pkg and imtf_crc.
`default_nettype none

module imtf_seq #(
    parameter int MAX_SIZE_CODE = imtf_pkg::MAX_SIZE_CODE_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic            i_kind,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_table_id_valid,
    input  wire logic [7:0]      i_table_id,
    input  wire imtf_pkg::t_cfg  i_cfg,
    output imtf_pkg::t_result    o_result
);

    imtf_pkg::t_phase r_phase, n_phase;
    logic [13:0]      r_count, n_count;
    logic [5:0]       r_sector, n_sector;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_total, n_total;
    logic             r_finished, n_finished;

    logic [15:0] w_crc_next;
    logic [7:0]  w_byte;
    logic [2:0]  w_eff_size;
    logic [14:0] w_len;
    logic [13:0] w_cnt_inc;
    logic        w_sect_end;
    logic        w_done;
    logic [7:0]  w_mark;

    // Size code clamped to the supported ceiling
    assign w_eff_size = (i_cfg.size_shift > 3'(MAX_SIZE_CODE)) ? 3'(MAX_SIZE_CODE)
                                                                : i_cfg.size_shift;

    imtf_crc u_crc (
        .i_crc  (r_crc),
        .i_byte (w_byte),
        .o_crc  (w_crc_next)
    );

    // Length of the current section
    always_comb begin
        case (r_phase)
            imtf_pkg::PH_GAP4A: w_len = imtf_pkg::LEN_GAP4A;
            imtf_pkg::PH_IAM,
            imtf_pkg::PH_IDPRE,
            imtf_pkg::PH_DPRE:  w_len = imtf_pkg::LEN_PRE;
            imtf_pkg::PH_GAP1:  w_len = imtf_pkg::LEN_GAP1;
            imtf_pkg::PH_IDFLD: w_len = imtf_pkg::LEN_IDFLD;
            imtf_pkg::PH_GAP2:  w_len = imtf_pkg::LEN_GAP2;
            imtf_pkg::PH_DATA:  w_len = imtf_pkg::LEN_SECT128 << w_eff_size;
            imtf_pkg::PH_DCRC:  w_len = imtf_pkg::LEN_DCRC;
            imtf_pkg::PH_GAP3: begin
                if (i_cfg.gap3_length != 8'd0) begin
                    w_len = {7'd0, i_cfg.gap3_length};
                end else if (i_cfg.mode_flags[0]) begin
                    w_len = imtf_pkg::LEN_GAP3_HD;
                end else begin
                    w_len = imtf_pkg::LEN_GAP3_DD;
                end
            end
            default:            w_len = 15'd0;
        endcase
    end

    assign w_mark     = i_cfg.mode_flags[1] ? imtf_pkg::MARK_DDAM : imtf_pkg::MARK_DAM;
    assign w_cnt_inc  = r_count + 14'd1;
    assign w_sect_end = (w_cnt_inc == 14'd0) || ({1'b0, w_cnt_inc} >= w_len);
    assign w_done     = r_finished || (r_phase == imtf_pkg::PH_DONE) ||
                        ((r_phase == imtf_pkg::PH_FILL) && (r_total >= i_cfg.track_len));

    // Byte selection for the current position
    always_comb begin
        case (r_phase)
            imtf_pkg::PH_IAM,
            imtf_pkg::PH_IDPRE,
            imtf_pkg::PH_DPRE: begin
                if (r_count < imtf_pkg::PRE_SYNC_END) begin
                    w_byte = imtf_pkg::BYTE_SYNC;
                end else if (r_count < imtf_pkg::PRE_A1_END) begin
                    w_byte = imtf_pkg::BYTE_A1;
                end else if (r_phase == imtf_pkg::PH_IAM) begin
                    w_byte = imtf_pkg::MARK_IAM;
                end else if (r_phase == imtf_pkg::PH_IDPRE) begin
                    w_byte = imtf_pkg::MARK_IDAM;
                end else begin
                    w_byte = w_mark;
                end
            end
            imtf_pkg::PH_IDFLD: begin
                case (r_count)
                    imtf_pkg::IDF_CYL:    w_byte = i_cfg.cylinder_number;
                    imtf_pkg::IDF_HEAD:   w_byte = i_cfg.head_number;
                    imtf_pkg::IDF_SECT:   w_byte = i_table_id_valid ? i_table_id
                                                 : i_cfg.first_id + {2'd0, r_sector};
                    imtf_pkg::IDF_SIZE:   w_byte = {5'd0, w_eff_size};
                    imtf_pkg::IDF_CRC_HI: w_byte = r_crc[15:8];
                    default:              w_byte = r_crc[7:0];
                endcase
            end
            imtf_pkg::PH_DATA:  w_byte = i_data_byte;
            imtf_pkg::PH_DCRC:  w_byte = (r_count == 14'd0) ? r_crc[15:8] : r_crc[7:0];
            default:            w_byte = imtf_pkg::BYTE_GAP;
        endcase
    end

    // Next state and result for an accepted transaction
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_sector   = r_sector;
        n_crc      = r_crc;
        n_total    = r_total;
        n_finished = r_finished;

        o_result.out_byte        = 8'd0;
        o_result.out_valid       = 1'b0;
        o_result.data_taken      = 1'b0;
        o_result.sector_position = 6'd0;
        o_result.track_done      = 1'b0;

        if (!i_kind) begin
            // Start of a new track
            n_phase    = imtf_pkg::PH_GAP4A;
            n_count    = 14'd0;
            n_sector   = 6'd0;
            n_crc      = 16'd0;
            n_total    = 16'd0;
            n_finished = 1'b0;
        end else if (w_done) begin
            n_phase                  = imtf_pkg::PH_DONE;
            n_finished               = 1'b1;
            o_result.sector_position = r_sector;
            o_result.track_done      = 1'b1;
        end else begin
            o_result.out_byte        = w_byte;
            o_result.out_valid       = 1'b1;
            o_result.data_taken      = (r_phase == imtf_pkg::PH_DATA);
            o_result.sector_position = r_sector;

            // CRC register
            case (r_phase)
                imtf_pkg::PH_IAM,
                imtf_pkg::PH_IDPRE,
                imtf_pkg::PH_DPRE: begin
                    if (r_count == imtf_pkg::PRE_LAST_A1) begin
                        n_crc = imtf_pkg::CRC_PRESET;
                    end else if (r_count >= imtf_pkg::PRE_A1_END) begin
                        n_crc = w_crc_next;
                    end
                end
                imtf_pkg::PH_IDFLD: begin
                    if (r_count < imtf_pkg::IDF_CRC_HI) begin
                        n_crc = w_crc_next;
                    end
                end
                imtf_pkg::PH_DATA: n_crc = w_crc_next;
                default: begin
                end
            endcase

            if (r_total != 16'hFFFF) begin
                n_total = r_total + 16'd1;
            end

            // Section sequencing
            if (r_phase != imtf_pkg::PH_FILL) begin
                n_count = w_cnt_inc;
                if (w_sect_end) begin
                    n_count = 14'd0;
                    case (r_phase)
                        imtf_pkg::PH_GAP4A: n_phase = imtf_pkg::PH_IAM;
                        imtf_pkg::PH_IAM:   n_phase = imtf_pkg::PH_GAP1;
                        imtf_pkg::PH_GAP1:  n_phase = (i_cfg.sector_count == 6'd0)
                                                    ? imtf_pkg::PH_FILL : imtf_pkg::PH_IDPRE;
                        imtf_pkg::PH_IDPRE: n_phase = imtf_pkg::PH_IDFLD;
                        imtf_pkg::PH_IDFLD: n_phase = imtf_pkg::PH_GAP2;
                        imtf_pkg::PH_GAP2:  n_phase = imtf_pkg::PH_DPRE;
                        imtf_pkg::PH_DPRE:  n_phase = imtf_pkg::PH_DATA;
                        imtf_pkg::PH_DATA:  n_phase = imtf_pkg::PH_DCRC;
                        imtf_pkg::PH_DCRC:  n_phase = (({1'b0, r_sector} + 7'd1) >=
                                                       {1'b0, i_cfg.sector_count})
                                                    ? imtf_pkg::PH_FILL : imtf_pkg::PH_GAP3;
                        imtf_pkg::PH_GAP3: begin
                            n_sector = r_sector + 6'd1;
                            n_phase  = imtf_pkg::PH_IDPRE;
                        end
                        default:            n_phase = imtf_pkg::PH_DONE;
                    endcase
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= imtf_pkg::PH_GAP4A;
            r_count    <= 14'd0;
            r_sector   <= 6'd0;
            r_crc      <= 16'd0;
            r_total    <= 16'd0;
            r_finished <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_sector   <= n_sector;
            r_crc      <= n_crc;
            r_total    <= n_total;
            r_finished <= n_finished;
        end
    end

    // A start transaction always leaves the sequencer at the head of gap 4a
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_kind) |=> (r_phase == imtf_pkg::PH_GAP4A && r_count == 14'd0 &&
                                   !r_finished && r_total == 16'd0))
        else $error("start did not clear sequencer state");

    // The done flag and the done section go together
    a_finished_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_phase == imtf_pkg::PH_DONE))
        else $error("finished flag set outside done section");

    // ID field and data CRC positions stay inside their sections
    a_short_sections: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == imtf_pkg::PH_IDFLD) |-> (r_count < 14'd6)) and
        ((r_phase == imtf_pkg::PH_DCRC) |-> (r_count < 14'd2)))
        else $error("byte position beyond section length");

    // Sector index only advances at the end of gap 3
    a_sector_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_kind && r_sector != n_sector) |-> (r_phase == imtf_pkg::PH_GAP3))
        else $error("sector index moved outside gap 3");

endmodule

`default_nettype wire

>>> tb/ibm_mfm_track_formatter_top_test.sv
// Self-checking testbench for the MFM format-track byte generator.
// Holds its own byte-level formatter model and scoreboard; needs imtf_pkg and
// ibm_mfm_track_formatter_top only.
`timescale 1ns / 100ps

module ibm_mfm_track_formatter_top_test;

    localparam int          SIZE_CODE_CAP = imtf_pkg::MAX_SIZE_CODE_DEF;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned SHOWN_ERRORS  = 10;

    // Request kinds
    localparam bit KIND_START = 1'b0;
    localparam bit KIND_NEXT  = 1'b1;

    // One row of the directed stimulus; byte/valid/done are only used when typed is set
    typedef struct packed {
        bit         kind;
        logic [7:0] dbyte;
        bit         tvalid;
        logic [7:0] tid;
        bit         typed;
        logic [7:0] byte_due;
        bit         valid_due;
        bit         done_due;
    } t_dir_row;

    localparam logic [7:0] GAP_BYTE = imtf_pkg::BYTE_GAP;

    localparam int DIR_ROWS = 12;
    localparam t_dir_row DIRECTED_ROWS [0:DIR_ROWS-1] = '{
        // straight from reset, no start transaction
        '{KIND_NEXT,  8'h00, 1'b0, 8'h00, 1'b1, GAP_BYTE, 1'b1, 1'b0},
        '{KIND_NEXT,  8'hFF, 1'b1, 8'hFF, 1'b1, GAP_BYTE, 1'b1, 1'b0},
        // start clears everything and answers with an all-zero result
        '{KIND_START, 8'hFF, 1'b1, 8'hFF, 1'b1, 8'h00,    1'b0, 1'b0},
        '{KIND_START, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00,    1'b0, 1'b0},
        '{KIND_NEXT,  8'h80, 1'b1, 8'h01, 1'b1, GAP_BYTE, 1'b1, 1'b0},
        '{KIND_NEXT,  8'h7F, 1'b0, 8'hFE, 1'b0, 8'h00,    1'b0, 1'b0},
        '{KIND_NEXT,  8'h01, 1'b1, 8'h80, 1'b0, 8'h00,    1'b0, 1'b0},
        '{KIND_START, 8'h55, 1'b1, 8'hAA, 1'b1, 8'h00,    1'b0, 1'b0},
        '{KIND_NEXT,  8'hAA, 1'b0, 8'h55, 1'b1, GAP_BYTE, 1'b1, 1'b0},
        '{KIND_NEXT,  8'hFE, 1'b1, 8'h7F, 1'b0, 8'h00,    1'b0, 1'b0},
        '{KIND_NEXT,  8'h00, 1'b1, 8'h00, 1'b0, 8'h00,    1'b0, 1'b0},
        '{KIND_NEXT,  8'hFF, 1'b0, 8'hFF, 1'b1, GAP_BYTE, 1'b1, 1'b0}
    };

    // DUT connections, all inputs known from time zero
    logic                            i_clk            = 1'b0;
    logic                            i_rst_n          = 1'b0;
    logic                            i_cfg_we         = 1'b0;
    logic [imtf_pkg::CFG_IDX_W-1:0]  i_cfg_idx        = '0;
    logic [imtf_pkg::CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                            i_valid          = 1'b0;
    logic                            i_kind           = 1'b0;
    logic [7:0]                      i_data_byte      = '0;
    logic                            i_table_id_valid = 1'b0;
    logic [7:0]                      i_table_id       = '0;
    logic                            i_ready          = 1'b0;
    logic                            o_ready;
    logic                            o_valid;
    logic [7:0]                      o_out_byte;
    logic                            o_out_valid;
    logic                            o_data_taken;
    logic [5:0]                      o_sector_position;
    logic                            o_track_done;

    ibm_mfm_track_formatter_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_kind            (i_kind),
        .i_data_byte       (i_data_byte),
        .i_table_id_valid  (i_table_id_valid),
        .i_table_id        (i_table_id),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_out_byte        (o_out_byte),
        .o_out_valid       (o_out_valid),
        .o_data_taken      (o_data_taken),
        .o_sector_position (o_sector_position),
        .o_track_done      (o_track_done)
    );

    always #5 i_clk = ~i_clk;

    // Formatter model state and its copy of the registers
    imtf_pkg::t_cfg   trk_cfg;
    imtf_pkg::t_phase trk_phase;
    logic [13:0]      trk_count;
    logic [5:0]       trk_sector;
    logic [15:0]      trk_crc;
    logic [15:0]      trk_total;
    logic [7:0]       trk_id;
    bit               trk_done;

    imtf_pkg::t_result track_bytes_due [$];
    int unsigned       wrong_results = 0;
    int unsigned       cycles        = 0;
    int unsigned       snd_idle_pct  = 0;
    int unsigned       rcv_idle_pct  = 0;

    function automatic logic [15:0] crc16_ccitt(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ imtf_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic logic [2:0] size_used();
        return (trk_cfg.size_shift > SIZE_CODE_CAP) ? 3'(SIZE_CODE_CAP) : trk_cfg.size_shift;
    endfunction

    function automatic int unsigned section_len(input imtf_pkg::t_phase p);
        case (p)
            imtf_pkg::PH_GAP4A: return imtf_pkg::LEN_GAP4A;
            imtf_pkg::PH_IAM,
            imtf_pkg::PH_IDPRE,
            imtf_pkg::PH_DPRE:  return imtf_pkg::LEN_PRE;
            imtf_pkg::PH_GAP1:  return imtf_pkg::LEN_GAP1;
            imtf_pkg::PH_IDFLD: return imtf_pkg::LEN_IDFLD;
            imtf_pkg::PH_GAP2:  return imtf_pkg::LEN_GAP2;
            imtf_pkg::PH_DATA:  return int'(imtf_pkg::LEN_SECT128) << size_used();
            imtf_pkg::PH_DCRC:  return imtf_pkg::LEN_DCRC;
            imtf_pkg::PH_GAP3: begin
                if (trk_cfg.gap3_length != 8'd0) return trk_cfg.gap3_length;
                return trk_cfg.mode_flags[0] ? imtf_pkg::LEN_GAP3_HD : imtf_pkg::LEN_GAP3_DD;
            end
            default:            return 0;
        endcase
    endfunction

    function automatic void clear_track();
        trk_phase  = imtf_pkg::PH_GAP4A;
        trk_count  = '0;
        trk_sector = '0;
        trk_crc    = '0;
        trk_total  = '0;
        trk_id     = '0;
        trk_done   = 1'b0;
    endfunction

    // Sync run, three A1s (CRC preset on the last one), then the address mark
    function automatic logic [7:0] preamble_byte(input logic [7:0] mark);
        if (trk_count < imtf_pkg::PRE_SYNC_END) return imtf_pkg::BYTE_SYNC;
        if (trk_count < imtf_pkg::PRE_A1_END) begin
            if (trk_count == imtf_pkg::PRE_LAST_A1) trk_crc = imtf_pkg::CRC_PRESET;
            return imtf_pkg::BYTE_A1;
        end
        trk_crc = crc16_ccitt(trk_crc, mark);
        return mark;
    endfunction

    // Next result of the formatter for one accepted request
    function automatic imtf_pkg::t_result format_next_byte(input bit kind,
                                                           input logic [7:0] dbyte,
                                                           input bit tvalid,
                                                           input logic [7:0] tid);
        imtf_pkg::t_result r;
        logic [7:0]        b;
        r = '0;
        if (kind == KIND_START) begin
            clear_track();
            return r;
        end
        if (trk_phase == imtf_pkg::PH_FILL && trk_total >= trk_cfg.track_len) begin
            trk_phase = imtf_pkg::PH_DONE;
            trk_done  = 1'b1;
        end
        if (trk_done || trk_phase > imtf_pkg::PH_FILL) begin
            trk_phase         = imtf_pkg::PH_DONE;
            trk_done          = 1'b1;
            r.sector_position = trk_sector;
            r.track_done      = 1'b1;
            return r;
        end

        b = imtf_pkg::BYTE_GAP;
        case (trk_phase)
            imtf_pkg::PH_IAM:   b = preamble_byte(imtf_pkg::MARK_IAM);
            imtf_pkg::PH_IDPRE: b = preamble_byte(imtf_pkg::MARK_IDAM);
            imtf_pkg::PH_DPRE:  b = preamble_byte(trk_cfg.mode_flags[1] ? imtf_pkg::MARK_DDAM
                                                                        : imtf_pkg::MARK_DAM);
            imtf_pkg::PH_IDFLD: begin
                case (trk_count)
                    imtf_pkg::IDF_CYL:    b = trk_cfg.cylinder_number;
                    imtf_pkg::IDF_HEAD:   b = trk_cfg.head_number;
                    imtf_pkg::IDF_SECT: begin
                        trk_id = tvalid ? tid : 8'(trk_cfg.first_id + {2'b00, trk_sector});
                        b = trk_id;
                    end
                    imtf_pkg::IDF_SIZE:   b = {5'd0, size_used()};
                    imtf_pkg::IDF_CRC_HI: b = trk_crc[15:8];
                    default:              b = trk_crc[7:0];
                endcase
                if (trk_count < imtf_pkg::IDF_CRC_HI) trk_crc = crc16_ccitt(trk_crc, b);
            end
            imtf_pkg::PH_DATA: begin
                b            = dbyte;
                r.data_taken = 1'b1;
                trk_crc      = crc16_ccitt(trk_crc, b);
            end
            imtf_pkg::PH_DCRC:  b = (trk_count == 14'd0) ? trk_crc[15:8] : trk_crc[7:0];
            default:            b = imtf_pkg::BYTE_GAP;
        endcase

        r.out_byte        = b;
        r.out_valid       = 1'b1;
        r.sector_position = trk_sector;
        if (trk_total != 16'hFFFF) trk_total = trk_total + 16'd1;

        // Section sequencing; filler just runs until the length check above
        if (trk_phase != imtf_pkg::PH_FILL) begin
            trk_count = trk_count + 14'd1;
            if (trk_count == 14'd0 || trk_count >= section_len(trk_phase)) begin
                trk_count = '0;
                case (trk_phase)
                    imtf_pkg::PH_GAP1:
                        trk_phase = (trk_cfg.sector_count == 6'd0) ? imtf_pkg::PH_FILL
                                                                   : imtf_pkg::PH_IDPRE;
                    imtf_pkg::PH_DCRC:
                        trk_phase = (int'(trk_sector) + 1 >= int'(trk_cfg.sector_count))
                                  ? imtf_pkg::PH_FILL : imtf_pkg::PH_GAP3;
                    imtf_pkg::PH_GAP3: begin
                        trk_sector = trk_sector + 6'd1;
                        trk_phase  = imtf_pkg::PH_IDPRE;
                    end
                    default:
                        trk_phase = imtf_pkg::t_phase'(trk_phase + 4'd1);
                endcase
            end
        end
        return r;
    endfunction

    function automatic imtf_pkg::t_cfg track_setup(input logic [7:0] cyl,
                                                   input logic [7:0] head,
                                                   input logic [2:0] size,
                                                   input logic [5:0] count,
                                                   input logic [7:0] first,
                                                   input logic [7:0] gap3,
                                                   input logic [15:0] len,
                                                   input logic [1:0] mode);
        imtf_pkg::t_cfg c;
        c.cylinder_number = cyl;
        c.head_number     = head;
        c.size_shift      = size;
        c.sector_count    = count;
        c.first_id        = first;
        c.gap3_length     = gap3;
        c.track_len       = len;
        c.mode_flags      = mode;
        return c;
    endfunction

    // Write all registers back to back; only called with the formatter idle
    task automatic load_settings(input imtf_pkg::t_cfg c);
        for (int idx = 0; idx < 8; idx++) begin
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= imtf_pkg::CFG_IDX_W'(idx);
            case (imtf_pkg::CFG_IDX_W'(idx))
                imtf_pkg::CFG_CYLINDER:   i_cfg_data <= {8'h00, c.cylinder_number};
                imtf_pkg::CFG_HEAD:       i_cfg_data <= {8'h00, c.head_number};
                imtf_pkg::CFG_SIZE_SHIFT: i_cfg_data <= {13'h0000, c.size_shift};
                imtf_pkg::CFG_SECT_COUNT: i_cfg_data <= {10'h000, c.sector_count};
                imtf_pkg::CFG_FIRST_SECT: i_cfg_data <= {8'h00, c.first_id};
                imtf_pkg::CFG_GAP3_LEN:   i_cfg_data <= {8'h00, c.gap3_length};
                imtf_pkg::CFG_TRACK_LEN:  i_cfg_data <= c.track_len;
                default:                  i_cfg_data <= {14'h0000, c.mode_flags};
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        trk_cfg = c;
    endtask

    // Present one request, wait for the transaction, then queue what it should produce
    task automatic issue_request(input bit kind, input logic [7:0] dbyte, input bit tvalid,
                                 input logic [7:0] tid, input bit typed,
                                 input imtf_pkg::t_result typed_res);
        imtf_pkg::t_result due;
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        i_valid          <= 1'b1;
        i_kind           <= kind;
        i_data_byte      <= dbyte;
        i_table_id_valid <= tvalid;
        i_table_id       <= tid;
        do @(posedge i_clk); while (!o_ready);
        due = format_next_byte(kind, dbyte, tvalid, tid);
        track_bytes_due.push_back(typed ? typed_res : due);
    endtask

    // Start a track and request bytes until done (plus a few) or until cap runs out
    task automatic run_track(input int unsigned cap);
        int unsigned tail;
        int unsigned n;
        tail = $urandom_range(1, 3);
        n    = 0;
        issue_request(KIND_START, 8'($urandom), 1'($urandom), 8'($urandom), 1'b0, '0);
        while (n < cap && !(trk_done && tail == 0)) begin
            if (trk_done) tail--;
            issue_request(KIND_NEXT, 8'($urandom), 1'($urandom), 8'($urandom), 1'b0, '0);
            n++;
        end
    endtask

    // Let every outstanding result drain before touching the registers
    task automatic settle();
        i_valid <= 1'b0;
        while (track_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic flag_wrong(input string what);
        wrong_results++;
        if (wrong_results <= SHOWN_ERRORS) $display("%s", what);
    endtask

    // Receiver stalls
    always @(posedge i_clk)
        i_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    // Scoreboard: each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        imtf_pkg::t_result got;
        imtf_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got.out_byte        = o_out_byte;
            got.out_valid       = o_out_valid;
            got.data_taken      = o_data_taken;
            got.sector_position = o_sector_position;
            got.track_done      = o_track_done;
            if (track_bytes_due.size() == 0) begin
                flag_wrong($sformatf({"unexpected result: byte %02h valid %0d taken %0d",
                           " pos %0d done %0d"},
                           got.out_byte, got.out_valid, got.data_taken,
                           got.sector_position, got.track_done));
            end else begin
                want = track_bytes_due.pop_front();
                if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
                    got.data_taken !== want.data_taken ||
                    got.sector_position !== want.sector_position ||
                    got.track_done !== want.track_done)
                    flag_wrong($sformatf({"wrong result: expected byte %02h valid %0d taken %0d",
                               " pos %0d done %0d, got byte %02h valid %0d taken %0d",
                               " pos %0d done %0d"},
                               want.out_byte, want.out_valid, want.data_taken,
                               want.sector_position, want.track_done,
                               got.out_byte, got.out_valid, got.data_taken,
                               got.sector_position, got.track_done));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ibm_mfm_track_formatter_top: mismatch");
            $finish;
        end
    end

    initial begin
        t_dir_row          row;
        imtf_pkg::t_result typed_res;

        trk_cfg = track_setup(8'd0, 8'd0, 3'd2, 6'd9, 8'd1, 8'd0, 16'd12500, 2'd0);
        clear_track();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows on reset settings, sender 23 % idle, receiver 71 %
        snd_idle_pct = 23;
        rcv_idle_pct = 71;
        for (int i = 0; i < DIR_ROWS; i++) begin
            row                  = DIRECTED_ROWS[i];
            typed_res            = '0;
            typed_res.out_byte   = row.byte_due;
            typed_res.out_valid  = row.valid_due;
            typed_res.track_done = row.done_due;
            issue_request(row.kind, row.dbyte, row.tvalid, row.tid, row.typed, typed_res);
        end
        settle();

        // Oversized size code, deleted mark, all-ones ID bytes, tracks cut in gap 4a or gap 2
        load_settings(track_setup(8'hFF, 8'hFF, 3'd7, 6'd63, 8'hFF, 8'hFF, 16'hFFFF, 2'd3));
        run_track($urandom_range(1, 20));
        run_track($urandom_range(170, 176));
        settle();

        // Roles swapped: one sector on the high-density layout, short filler, then done
        snd_idle_pct = 71;
        rcv_idle_pct = 23;
        load_settings(track_setup(8'hA5, 8'h5A, 3'd0, 6'd1, 8'hFF, 8'd0, 16'd340, 2'd1));
        run_track(400);
        settle();

        // No idling: zero sectors, back-to-back requests, broken tracks
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        load_settings(track_setup(8'h3C, 8'h01, 3'd0, 6'd0, 8'd1, 8'd3, 16'd160, 2'd0));
        run_track($urandom_range(10, 30));
        run_track($urandom_range(10, 30));
        settle();

        if (wrong_results == 0 && track_bytes_due.size() == 0)
            $display("ibm_mfm_track_formatter_top: match");
        else
            $display("ibm_mfm_track_formatter_top: mismatch");
        $finish;
    end

endmodule
